@@ design/scbg_pkg.sv @@
// ----------------------------------------------------------------------------
// scbg_pkg - shared types and constants for the colour bar generator
// Pixel record, configuration write request and the fixed YUV bar tables.
// ----------------------------------------------------------------------------
package scbg_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;

    // geometry after reset
    localparam int DEF_WIDTH  = 1280;
    localparam int DEF_HEIGHT = 720;
    localparam int MIN_WIDTH  = 8;
    localparam int MIN_HEIGHT = 1;

    // bar index saturates here; bar 7 and beyond are black
    localparam logic [3:0] BAR_MAX   = 4'd15;
    localparam logic [3:0] BAR_BLACK = 4'd7;

    typedef logic [7:0] t_byte;

    // bar colours: white, yellow, cyan, green, magenta, red, blue, black
    localparam t_byte BAR_Y     [8] = '{8'd180, 8'd162, 8'd131, 8'd112,
                                        8'd84,  8'd65,  8'd35,  8'd16};
    // floor(y * 8 / 10) of the row above
    localparam t_byte BAR_Y_DIM [8] = '{8'd144, 8'd129, 8'd104, 8'd89,
                                        8'd67,  8'd52,  8'd28,  8'd12};
    localparam t_byte BAR_U     [8] = '{8'd128, 8'd44,  8'd156, 8'd72,
                                        8'd184, 8'd100, 8'd212, 8'd128};
    localparam t_byte BAR_V     [8] = '{8'd128, 8'd142, 8'd44,  8'd58,
                                        8'd198, 8'd212, 8'd114, 8'd128};

    typedef struct packed {
        logic                   valid;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } t_cfg_wr;

    typedef struct packed {
        t_byte luma;
        t_byte chroma_blue;
        t_byte chroma_red;
        logic  chroma_valid;
        logic  end_of_line;
        logic  end_of_frame;
    } t_pix;

endpackage

@@ design/scrolling_color_bar_generator_core.sv @@
// ----------------------------------------------------------------------------
// scrolling_color_bar_generator_core - scrolling colour bar test pattern
// Emits one YUV pixel per request in raster order over eight colour bars.
// ----------------------------------------------------------------------------
// a taken request's pixel is registered into the result register, or into the skid while that is stalled
// throughput: one pixel per cycle while the pixel side is not stalled, set by the raster update on each taken request
// a two-entry output stage (result register plus skid) keeps tready registered
// reset: synchronous, active low; clears the raster counters and sets the
// geometry to 1280 x 720 (clamped to MAX_DIMENSION)
// ----------------------------------------------------------------------------
module scrolling_color_bar_generator_core #(
    parameter int MAX_DIMENSION = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request side
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [0] restart_pattern, rest zero
    // pixel side
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [7:0] luma, [15:8] chroma_blue,
                                          // [23:16] chroma_red
    output logic        o_m_axis_tlast,   // end_of_line
    output logic [1:0]  o_m_axis_tuser,   // [0] chroma_valid, [1] end_of_frame
    // register writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data
);
    import scbg_pkg::*;

    t_cfg_wr cfg;
    t_pix    pix;
    t_pix    r_out, r_skid;
    logic    r_out_valid, r_skid_valid;
    logic    accept, out_free;

    // registers are always writable; the user must write them only while idle, the block does not enforce it
    assign o_cfg_ready = 1'b1;
    assign cfg.valid   = i_cfg_valid;
    assign cfg.index   = i_cfg_index;
    assign cfg.data    = i_cfg_data;

    // ready depends only on the skid entry, never on the downstream ready
    assign o_s_axis_tready = ~r_skid_valid;
    assign accept          = i_s_axis_tvalid & o_s_axis_tready;

    scbg_pixel #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_pixel (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_step    (accept),
        .i_restart (i_s_axis_tdata[0]),
        .o_pix     (pix)
    );

    // output register is free when empty or being taken this cycle
    assign out_free = ~r_out_valid | i_m_axis_tready;

    // control of the two output entries
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= accept;
            end
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    // payload of the two output entries, no reset needed
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (accept) begin
                r_out <= pix;
            end
        end else if (accept) begin
            r_skid <= pix;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out.chroma_red, r_out.chroma_blue, r_out.luma};
    assign o_m_axis_tlast  = r_out.end_of_line;
    assign o_m_axis_tuser  = {r_out.end_of_frame, r_out.chroma_valid};

endmodule

@@ design/scbg_pixel.sv @@
// ----------------------------------------------------------------------------
// scbg_pixel - raster counters and pixel colour logic
// Holds the geometry registers and the raster state; gives the pixel for
// the current request and advances the state when the request is taken.
// ----------------------------------------------------------------------------
module scbg_pixel #(
    parameter int MAX_DIMENSION = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  scbg_pkg::t_cfg_wr i_cfg,
    input  logic             i_step,
    input  logic             i_restart,
    output scbg_pkg::t_pix   o_pix
);
    import scbg_pkg::*;

    localparam int CW = $clog2(MAX_DIMENSION);
    localparam int DW = $clog2(MAX_DIMENSION + 1);
    localparam int PW = DW - 3;
    localparam int SW = DW - 2;

    localparam logic [DW-1:0] RST_W =
        DW'((DEF_WIDTH > MAX_DIMENSION) ? MAX_DIMENSION : DEF_WIDTH);
    localparam logic [DW-1:0] RST_H =
        DW'((DEF_HEIGHT > MAX_DIMENSION) ? MAX_DIMENSION : DEF_HEIGHT);

    logic [DW-1:0] r_eff_w, r_eff_h;
    logic [CW-1:0] r_col, r_row;
    logic [3:0]    r_bar;
    logic [PW-1:0] r_pos, r_scroll;

    logic [CW-1:0] c_col, c_row;
    logic [3:0]    c_bar;
    logic [PW-1:0] c_pos, c_scroll;
    logic [2:0]    sel;
    logic [SW-1:0] bw, sum, pos_inc, scr_a, scr_b, scr_c;
    logic          dim, eol, eof;
    logic [DW-1:0] n_eff_w, n_eff_h;

    // restart zeroes the raster state ahead of this pixel
    always_comb begin
        c_col    = i_restart ? '0 : r_col;
        c_row    = i_restart ? '0 : r_row;
        c_bar    = i_restart ? '0 : r_bar;
        c_pos    = i_restart ? '0 : r_pos;
        c_scroll = i_restart ? '0 : r_scroll;
    end

    assign bw  = {1'b0, r_eff_w[DW-1:3]};
    assign sel = (c_bar < BAR_BLACK) ? c_bar[2:0] : BAR_BLACK[2:0];
    assign sum = SW'(c_pos) + SW'(c_scroll);
    assign dim = (sum >= bw);
    assign eol = ((DW+1)'(c_col) + (DW+1)'(1)) >= (DW+1)'(r_eff_w);
    assign eof = eol && (((DW+1)'(c_row) + (DW+1)'(1)) >= (DW+1)'(r_eff_h));

    assign pos_inc = SW'(c_pos) + SW'(1);
    assign scr_a   = SW'(c_scroll) + SW'(2);
    assign scr_b   = (scr_a >= bw) ? scr_a - bw : scr_a;
    assign scr_c   = (scr_b >= bw) ? scr_b - bw : scr_b;

    always_comb begin
        o_pix.luma         = dim ? BAR_Y_DIM[sel] : BAR_Y[sel];
        o_pix.chroma_blue  = BAR_U[sel];
        o_pix.chroma_red   = BAR_V[sel];
        o_pix.chroma_valid = ~c_row[0] & ~c_col[0];
        o_pix.end_of_line  = eol;
        o_pix.end_of_frame = eof;
    end

    // clamp register writes into the supported range
    always_comb begin
        if (32'(i_cfg.data) < MIN_WIDTH) begin
            n_eff_w = DW'(MIN_WIDTH);
        end else if (32'(i_cfg.data) > MAX_DIMENSION) begin
            n_eff_w = DW'(MAX_DIMENSION);
        end else begin
            n_eff_w = DW'(i_cfg.data);
        end
        if (32'(i_cfg.data) < MIN_HEIGHT) begin
            n_eff_h = DW'(MIN_HEIGHT);
        end else if (32'(i_cfg.data) > MAX_DIMENSION) begin
            n_eff_h = DW'(MAX_DIMENSION);
        end else begin
            n_eff_h = DW'(i_cfg.data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff_w  <= RST_W;
            r_eff_h  <= RST_H;
            r_col    <= '0;
            r_row    <= '0;
            r_bar    <= '0;
            r_pos    <= '0;
            r_scroll <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_IMAGE_WIDTH: begin
                    r_eff_w  <= n_eff_w;
                    r_col    <= '0;
                    r_row    <= '0;
                    r_bar    <= '0;
                    r_pos    <= '0;
                    r_scroll <= '0;
                end
                REG_IMAGE_HEIGHT: begin
                    r_eff_h  <= n_eff_h;
                    r_col    <= '0;
                    r_row    <= '0;
                    r_bar    <= '0;
                    r_pos    <= '0;
                    r_scroll <= '0;
                end
                default: begin
                end
            endcase
        end else if (i_step) begin
            if (eol) begin
                r_col <= '0;
                r_bar <= '0;
                r_pos <= '0;
                if (eof) begin
                    r_row    <= '0;
                    r_scroll <= scr_c[PW-1:0];
                end else begin
                    r_row    <= c_row + CW'(1);
                    r_scroll <= c_scroll;
                end
            end else begin
                r_col    <= c_col + CW'(1);
                r_row    <= c_row;
                r_scroll <= c_scroll;
                if (pos_inc >= bw) begin
                    r_pos <= '0;
                    r_bar <= (c_bar != BAR_MAX) ? c_bar + 4'd1 : c_bar;
                end else begin
                    r_pos <= pos_inc[PW-1:0];
                    r_bar <= c_bar;
                end
            end
        end
    end

endmodule

@@ design/scbg_checker.sv @@
// ----------------------------------------------------------------------------
// scbg_checker - port-level checks for the colour bar generator
// Watches the top-level ports and flags ordering and flow-control slips.
// ----------------------------------------------------------------------------
module scbg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [23:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast,
    input logic [1:0]  o_m_axis_tuser
);

    // end of frame is always also end of line
    a_eof_is_eol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[1] |-> o_m_axis_tlast)
        else $error("end of frame without end of line");

    // a stalled pixel holds its payload
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) &&
            $stable(o_m_axis_tlast) && $stable(o_m_axis_tuser))
        else $error("stalled pixel changed");

    // back-pressure upstream only while a pixel waits downstream
    a_bp_needs_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid)
        else $error("request side stalled with no pending pixel");

    // nothing presented right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("output not empty after reset");

endmodule

bind scrolling_color_bar_generator_core scbg_checker u_scbg_checker (.*);
